>>> hdl/bitmap_page_range_allocator_macros.svh
// ----------------------------------------------------------------------------
// bitmap page range allocator assertion macros
// concurrent checks sampled on clk_i, optionally gated by reset
// ----------------------------------------------------------------------------
`ifndef BITMAP_PAGE_RANGE_ALLOCATOR_MACROS_SVH
`define BITMAP_PAGE_RANGE_ALLOCATOR_MACROS_SVH

`ifndef NO_ASSERTIONS
// check that holds outside reset
`define BPRA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// check that holds at every edge, reset included
`define BPRA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define BPRA_ASSERT(lbl, prop, msg)
`define BPRA_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

>>> hdl/bpra_pkg.sv
// ----------------------------------------------------------------------------
// bpra_pkg
// shared sizes, codes and types of the bitmap page range allocator
// ----------------------------------------------------------------------------
package bpra_pkg;

  // sizing
  localparam int NUM_RANGES      = 5;
  localparam int PAGES_PER_RANGE = 256 * 32;
  localparam int PAGE_BYTES      = 4096;
  localparam int PAGE_SHIFT      = $clog2(PAGE_BYTES);
  localparam int WORD_BITS       = 32;
  localparam int BIT_W           = $clog2(WORD_BITS);
  localparam int WORDS           = PAGES_PER_RANGE / WORD_BITS;
  localparam int WORD_W          = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int RANGE_W         = 3;
  localparam int CNT_W           = $clog2(NUM_RANGES + 1);
  localparam int MEM_DEPTH       = NUM_RANGES * WORDS;
  localparam int MEM_AW          = RANGE_W + WORD_W;
  localparam int PAGE_W          = 14;
  localparam int ADDR_W          = 48;
  localparam int TYPE_W          = 8;

  // memory map types taken by a claim
  localparam logic [TYPE_W-1:0] TYPE_AVAILABLE   = 8'd1;
  localparam logic [TYPE_W-1:0] TYPE_RECLAIMABLE = 8'd3;

  // command and result codes
  typedef enum logic [1:0] {
    OP_CLAIM  = 2'd0,
    OP_ALLOC  = 2'd1,
    OP_REPORT = 2'd2
  } op_e;

  // status of one bitmap word from the word unit
  typedef struct packed {
    logic              hit;
    logic [BIT_W-1:0]  hit_bit;
    logic [PAGE_W-1:0] run_out;
    logic              free_any;
    logic [BIT_W-1:0]  free_bit;
  } scan_t;

  // one result item
  typedef struct packed {
    logic [1:0]         kind;
    logic               ok;
    logic [ADDR_W-1:0]  addr;
    logic [RANGE_W-1:0] idx;
    logic [PAGE_W-1:0]  used;
    logic               last;
  } res_t;

endpackage

>>> hdl/bpra_ram.sv
// ----------------------------------------------------------------------------
// bpra_ram
// generic simple dual port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module bpra_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> hdl/bpra_word_unit.sv
// ----------------------------------------------------------------------------
// bpra_word_unit
// shared evaluator of one bitmap word: free run search, first free page
// and page span mask
// ----------------------------------------------------------------------------
module bpra_word_unit import bpra_pkg::*; (
  input  logic [WORD_BITS-1:0] word_i,
  input  logic [PAGE_W-1:0]    run_i,
  input  logic [PAGE_W-1:0]    count_i,
  input  logic [PAGE_W-1:0]    base_i,
  input  logic [PAGE_W-1:0]    lo_i,
  input  logic [PAGE_W-1:0]    hi_i,
  output scan_t                scan_o,
  output logic [WORD_BITS-1:0] mask_o
);

  logic [PAGE_W-1:0]    run_at [WORD_BITS];
  logic [WORD_BITS-1:0] reach;

  // run length of free pages ending at each bit
  always_comb begin
    int  l;
    logic seen;
    for (int i = 0; i < WORD_BITS; i++) begin
      l    = 0;
      seen = 1'b0;
      for (int j = 0; j <= i; j++) begin
        if (word_i[j]) begin
          l    = j + 1;
          seen = 1'b1;
        end
      end
      if (seen) begin
        run_at[i] = PAGE_W'(i + 1 - l);
      end else begin
        run_at[i] = run_i + PAGE_W'(i + 1);
      end
      reach[i] = (run_at[i] >= count_i);
    end
  end

  // first bit where the run is long enough, first free bit
  always_comb begin
    scan_o = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (reach[i]) begin
        scan_o.hit     = 1'b1;
        scan_o.hit_bit = BIT_W'(i);
      end
      if (!word_i[i]) begin
        scan_o.free_any = 1'b1;
        scan_o.free_bit = BIT_W'(i);
      end
    end
    scan_o.run_out = run_at[WORD_BITS-1];
  end

  // pages of this word inside [lo, hi]
  always_comb begin
    logic [PAGE_W-1:0] pg;
    for (int i = 0; i < WORD_BITS; i++) begin
      pg        = base_i + PAGE_W'(i);
      mask_o[i] = (pg >= lo_i) && (pg <= hi_i);
    end
  end

endmodule

>>> hdl/bitmap_page_range_allocator.sv
// ----------------------------------------------------------------------------
// bitmap_page_range_allocator
// boot time first fit page allocator over up to five claimed ranges, each
// with a bitmap of pages held in one ram and walked a word per step
// ----------------------------------------------------------------------------
//  channel   | handshake                 | payload
//  ----------+---------------------------+-------------------------------------
//  command   | start, busy               | opcode, region_type/address/length,
//            |                           | page_count
//  result    | strobe_o (one cycle)      | result_kind, ok, address,
//            |                           | range_index, pages_used, last
//
//  after reset a clearing pass sets all 1280 bitmap words to used; busy is
//  high throughout it. claim writes each bitmap word of its range once,
//  allocate reads and evaluates one bitmap word per step until a run fits,
//  then reads and rewrites each word that the run covers; report reads each
//  claimed range word by word up to its first free page.
//  a result is shown for one cycle; the receiver cannot stall it.
// ----------------------------------------------------------------------------
module bitmap_page_range_allocator import bpra_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         opcode_i,
  input  logic [TYPE_W-1:0]  region_type_i,
  input  logic [ADDR_W-1:0]  region_address_i,
  input  logic [ADDR_W-1:0]  region_length_i,
  input  logic [PAGE_W-1:0]  page_count_i,
  output logic               strobe_o,
  output logic [1:0]         result_kind_o,
  output logic               ok_o,
  output logic [ADDR_W-1:0]  address_o,
  output logic [RANGE_W-1:0] range_index_o,
  output logic [PAGE_W-1:0]  pages_used_o,
  output logic               last_o
);

`include "bitmap_page_range_allocator_macros.svh"

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_CLAIM_WR, ST_AL_RD, ST_AL_EV,
    ST_MK_RD, ST_MK_WR, ST_RP_CHK, ST_RP_RD, ST_RP_EV
  } state_e;

  localparam logic [WORD_W-1:0]  LastWord  = WORD_W'(WORDS - 1);
  localparam logic [RANGE_W-1:0] LastRange = RANGE_W'(NUM_RANGES - 1);

  state_e             state_q;
  logic [RANGE_W-1:0] r_q;
  logic [WORD_W-1:0]  w_q;
  logic [CNT_W-1:0]   claimed_q;
  logic [PAGE_W-1:0]  run_q;
  logic [PAGE_W-1:0]  count_q;
  logic [PAGE_W-1:0]  npages_q;
  logic [PAGE_W-1:0]  first_q;
  logic [PAGE_W-1:0]  lastp_q;
  logic [ADDR_W-1:0]  range_start_q [NUM_RANGES];
  logic               strobe_q;
  res_t               res_q;

  logic [WORD_BITS-1:0] rdata;
  logic [WORD_BITS-1:0] mask;
  logic [WORD_BITS-1:0] wdata;
  logic                 we;
  scan_t                scan;
  logic [PAGE_W-1:0]    base;
  logic [PAGE_W-1:0]    lo;
  logic [PAGE_W-1:0]    hi;
  logic [PAGE_W-1:0]    hit_page;
  logic [PAGE_W-1:0]    free_page;
  logic [ADDR_W-1:0]    len_pages;
  logic [PAGE_W-1:0]    claim_pages;
  logic [ADDR_W-1:0]    claim_start;
  logic                 claim_bad;
  logic                 alloc_bad;
  logic                 range_unclaimed;

  function automatic res_t make_res(logic [1:0] kind, logic ok, logic [ADDR_W-1:0] addr,
                                    logic [RANGE_W-1:0] idx, logic [PAGE_W-1:0] used,
                                    logic last);
    res_t r;
    r.kind = kind;
    r.ok   = ok;
    r.addr = addr;
    r.idx  = idx;
    r.used = used;
    r.last = last;
    return r;
  endfunction

  // claim decode at the command
  assign len_pages   = region_length_i >> PAGE_SHIFT;
  assign claim_pages = (len_pages > ADDR_W'(PAGES_PER_RANGE)) ?
                       PAGE_W'(PAGES_PER_RANGE) : len_pages[PAGE_W-1:0];
  assign claim_start = (region_address_i + ADDR_W'(PAGE_BYTES - 1)) &
                       ~ADDR_W'(PAGE_BYTES - 1);
  assign claim_bad   = !((region_type_i == TYPE_AVAILABLE) ||
                         (region_type_i == TYPE_RECLAIMABLE)) ||
                       (claimed_q == CNT_W'(NUM_RANGES)) || (len_pages == '0);
  assign alloc_bad   = (page_count_i == '0) ||
                       (page_count_i > PAGE_W'(PAGES_PER_RANGE)) || (claimed_q == '0);
  assign range_unclaimed = (CNT_W'(r_q) >= claimed_q);

  // word unit operands
  assign base      = PAGE_W'({w_q, {BIT_W{1'b0}}});
  assign lo        = (state_q == ST_CLAIM_WR) ? '0 : first_q;
  assign hi        = (state_q == ST_CLAIM_WR) ? (npages_q - PAGE_W'(1)) : lastp_q;
  assign hit_page  = base + PAGE_W'(scan.hit_bit);
  assign free_page = base + PAGE_W'(scan.free_bit);

  bpra_word_unit u_word (
    .word_i  (rdata),
    .run_i   (run_q),
    .count_i (count_q),
    .base_i  (base),
    .lo_i    (lo),
    .hi_i    (hi),
    .scan_o  (scan),
    .mask_o  (mask)
  );

  // bitmap write data per phase
  always_comb begin
    we    = 1'b0;
    wdata = '1;
    unique case (state_q)
      ST_CLEAR: begin
        we = 1'b1;
      end
      ST_CLAIM_WR: begin
        we    = 1'b1;
        wdata = ~mask;
      end
      ST_MK_WR: begin
        we    = 1'b1;
        wdata = rdata | mask;
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  bpra_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (MEM_DEPTH)
  ) u_bitmap (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i ({r_q, w_q}),
    .wdata_i (wdata),
    .raddr_i ({r_q, w_q}),
    .rdata_o (rdata)
  );

  // sequencer and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      r_q       <= '0;
      w_q       <= '0;
      claimed_q <= '0;
      run_q     <= '0;
      count_q   <= '0;
      npages_q  <= '0;
      first_q   <= '0;
      lastp_q   <= '0;
      strobe_q  <= 1'b0;
      res_q     <= '0;
      for (int i = 0; i < NUM_RANGES; i++) begin
        range_start_q[i] <= '0;
      end
    end else begin
      strobe_q <= 1'b0;
      unique case (state_q)
        ST_CLEAR: begin
          if (w_q == LastWord) begin
            w_q <= '0;
            if (r_q == LastRange) begin
              r_q     <= '0;
              state_q <= ST_IDLE;
            end else begin
              r_q <= r_q + RANGE_W'(1);
            end
          end else begin
            w_q <= w_q + WORD_W'(1);
          end
        end
        ST_IDLE: begin
          if (start) begin
            unique case (opcode_i)
              OP_CLAIM: begin
                if (claim_bad) begin
                  strobe_q <= 1'b1;
                  res_q    <= make_res(OP_CLAIM, 1'b0, '0, '0, '0, 1'b1);
                end else begin
                  range_start_q[claimed_q[RANGE_W-1:0]] <= claim_start;
                  r_q       <= claimed_q[RANGE_W-1:0];
                  w_q       <= '0;
                  npages_q  <= claim_pages;
                  claimed_q <= claimed_q + CNT_W'(1);
                  state_q   <= ST_CLAIM_WR;
                end
              end
              OP_ALLOC: begin
                if (alloc_bad) begin
                  strobe_q <= 1'b1;
                  res_q    <= make_res(OP_ALLOC, 1'b0, '0, '0, '0, 1'b1);
                end else begin
                  r_q     <= '0;
                  w_q     <= '0;
                  run_q   <= '0;
                  count_q <= page_count_i;
                  state_q <= ST_AL_RD;
                end
              end
              OP_REPORT: begin
                r_q     <= '0;
                state_q <= ST_RP_CHK;
              end
              default: begin
                state_q <= ST_IDLE;
              end
            endcase
          end
        end
        ST_CLAIM_WR: begin
          if (w_q == LastWord) begin
            strobe_q <= 1'b1;
            res_q    <= make_res(OP_CLAIM, 1'b1, range_start_q[r_q], r_q, '0, 1'b1);
            state_q  <= ST_IDLE;
          end else begin
            w_q <= w_q + WORD_W'(1);
          end
        end
        ST_AL_RD: begin
          state_q <= ST_AL_EV;
        end
        ST_AL_EV: begin
          if (scan.hit) begin
            lastp_q <= hit_page;
            first_q <= hit_page + PAGE_W'(1) - count_q;
            w_q     <= WORD_W'((hit_page + PAGE_W'(1) - count_q) >> BIT_W);
            state_q <= ST_MK_RD;
          end else if (w_q == LastWord) begin
            if (CNT_W'(r_q) + CNT_W'(1) == claimed_q) begin
              strobe_q <= 1'b1;
              res_q    <= make_res(OP_ALLOC, 1'b0, '0, '0, '0, 1'b1);
              state_q  <= ST_IDLE;
            end else begin
              r_q     <= r_q + RANGE_W'(1);
              w_q     <= '0;
              run_q   <= '0;
              state_q <= ST_AL_RD;
            end
          end else begin
            w_q     <= w_q + WORD_W'(1);
            run_q   <= scan.run_out;
            state_q <= ST_AL_RD;
          end
        end
        ST_MK_RD: begin
          state_q <= ST_MK_WR;
        end
        ST_MK_WR: begin
          if (w_q == WORD_W'(lastp_q >> BIT_W)) begin
            strobe_q <= 1'b1;
            res_q    <= make_res(OP_ALLOC, 1'b1,
                                 range_start_q[r_q] +
                                 {{(ADDR_W-PAGE_W-PAGE_SHIFT){1'b0}}, first_q,
                                  {PAGE_SHIFT{1'b0}}},
                                 r_q, '0, 1'b1);
            state_q  <= ST_IDLE;
          end else begin
            w_q     <= w_q + WORD_W'(1);
            state_q <= ST_MK_RD;
          end
        end
        ST_RP_CHK: begin
          if (range_unclaimed) begin
            strobe_q <= 1'b1;
            res_q    <= make_res(OP_REPORT, 1'b0, range_start_q[r_q], r_q, '0,
                                 r_q == LastRange);
            if (r_q == LastRange) begin
              state_q <= ST_IDLE;
            end else begin
              r_q <= r_q + RANGE_W'(1);
            end
          end else begin
            w_q     <= '0;
            state_q <= ST_RP_RD;
          end
        end
        ST_RP_RD: begin
          state_q <= ST_RP_EV;
        end
        ST_RP_EV: begin
          if (scan.free_any || (w_q == LastWord)) begin
            strobe_q <= 1'b1;
            res_q    <= make_res(OP_REPORT, scan.free_any, range_start_q[r_q], r_q,
                                 scan.free_any ? free_page : '0, r_q == LastRange);
            if (r_q == LastRange) begin
              state_q <= ST_IDLE;
            end else begin
              r_q     <= r_q + RANGE_W'(1);
              state_q <= ST_RP_CHK;
            end
          end else begin
            w_q     <= w_q + WORD_W'(1);
            state_q <= ST_RP_RD;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign busy          = (state_q != ST_IDLE);
  assign strobe_o      = strobe_q;
  assign result_kind_o = res_q.kind;
  assign ok_o          = res_q.ok;
  assign address_o     = res_q.addr;
  assign range_index_o = res_q.idx;
  assign pages_used_o  = res_q.used;
  assign last_o        = res_q.last;

  // checks
  `BPRA_ASSERT(a_claimed_bound, claimed_q <= CNT_W'(NUM_RANGES), "claimed count overflow")
  `BPRA_ASSERT(a_single_last, strobe_o && (result_kind_o != OP_REPORT) |-> last_o,
               "claim or allocate result without last")
  `BPRA_ASSERT(a_report_ok_claimed,
               strobe_o && (result_kind_o == OP_REPORT) && ok_o |->
               (CNT_W'(range_index_o) < claimed_q), "free page reported in unclaimed range")
  `BPRA_ASSERT(a_cmd_goes_busy,
               start && !busy && ((opcode_i == OP_CLAIM && !claim_bad) ||
               (opcode_i == OP_ALLOC && !alloc_bad) || opcode_i == OP_REPORT) |=> busy,
               "accepted command did not start work")
  `BPRA_ASSERT_ALWAYS(a_reset_busy, !rst_ni |=> busy, "idle after reset")

endmodule
